FILE: rtl/core/smt_pkg.sv
// ----------------------------------------------------------------------------
// smt_pkg
// Shared types and constants of the sorted multiset table: request modes,
// update operations, count limits and the controller command bundle.
// ----------------------------------------------------------------------------
package smt_pkg;

  // request mode codes
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE_MIN = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE_MAX = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOOKUP     = 3'd4;

  // cell array update chosen in the decide cycle
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NOP = 3'd0;
  localparam logic [OP_W-1:0] OP_INC = 3'd1;
  localparam logic [OP_W-1:0] OP_INS = 3'd2;
  localparam logic [OP_W-1:0] OP_DEC = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL = 3'd4;

  // occurrence counters
  localparam int COUNT_W = 16;
  localparam int TOTAL_W = 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

  // stream payload widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_VAL_W  = 32;
  localparam int OUT_DATA_W = 88;

  // controller to datapath commands
  typedef struct packed {
    logic decide;    // compare request against all cells, register the decision
    logic apply;     // update cells and counters with the decision
    logic load_out;  // capture result into the output register
  } cmd_t;

endpackage

FILE: rtl/core/smt_ctrl.sv
// ----------------------------------------------------------------------------
// smt_ctrl
// Request sequencer: takes a request, runs the apply step and hands the
// result to the output register when the downstream side has room.
// ----------------------------------------------------------------------------
module smt_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  logic         m_tready,
  output smt_pkg::cmd_t cmd
);
  import smt_pkg::*;

  localparam logic [0:0] ST_IDLE  = 1'b0;
  localparam logic [0:0] ST_APPLY = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;
  logic       pending;
  logic       pending_next;
  logic       m_tvalid_next;
  logic       out_free;
  logic       accept;

  // handshake and command decode
  always_comb begin
    out_free     = !m_tvalid || m_tready;
    s_tready     = (state == ST_IDLE) && (!pending || out_free);
    accept       = s_tvalid && s_tready;
    cmd.decide   = accept;
    cmd.apply    = (state == ST_APPLY);
    cmd.load_out = (state == ST_IDLE) && pending && out_free;
  end

  // next state
  always_comb begin
    state_next    = state;
    pending_next  = pending;
    m_tvalid_next = m_tvalid;
    if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
    if (cmd.load_out) begin
      m_tvalid_next = 1'b1;
      pending_next  = 1'b0;
    end
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_next   = ST_IDLE;
        pending_next = 1'b1;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pending  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      pending  <= pending_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

FILE: rtl/core/smt_datapath.sv
// ----------------------------------------------------------------------------
// smt_datapath
// Sorted cell array with per-cell compare, the decision register, the
// shift/update logic and the result register.
// ----------------------------------------------------------------------------
module smt_datapath #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  smt_pkg::cmd_t                     cmd,
  input  logic [smt_pkg::MODE_W-1:0]        mode,
  input  logic [smt_pkg::IN_DATA_W-1:0]     value_in,
  output logic [smt_pkg::OUT_DATA_W-1:0]    out_data
);
  import smt_pkg::*;

  localparam int USED_W = $clog2(CAPACITY + 1);

  // cell array, ascending; cells at or above used hold nothing
  logic signed [VALUE_BITS-1:0] cell_val [CAPACITY];
  logic        [COUNT_W-1:0]    cell_cnt [CAPACITY];
  logic        [USED_W-1:0]     used;
  logic        [TOTAL_W-1:0]    total;

  // registered decision
  logic        [OP_W-1:0]       dec_op;
  logic        [CAPACITY-1:0]   dec_tgt;
  logic        [CAPACITY-1:0]   dec_ge;
  logic signed [VALUE_BITS-1:0] dec_value;
  logic                         dec_found;
  logic                         dec_rej;

  // result register
  logic                         res_found;
  logic        [OUT_VAL_W-1:0]  res_min;
  logic        [OUT_VAL_W-1:0]  res_max;
  logic                         res_valid;
  logic        [TOTAL_W-1:0]    res_total;
  logic                         res_rej;

  logic signed [VALUE_BITS-1:0] req_value;
  logic        [CAPACITY-1:0]   valid;
  logic        [CAPACITY-1:0]   lt;
  logic        [CAPACITY-1:0]   eq;
  logic        [CAPACITY-1:0]   last;
  logic        [CAPACITY-1:0]   first_ge;
  logic                         present;
  logic        [COUNT_W-1:0]    eq_cnt;
  logic        [COUNT_W-1:0]    tgt_cnt;
  logic        [OP_W-1:0]       d_op;
  logic        [CAPACITY-1:0]   d_tgt;
  logic        [CAPACITY-1:0]   d_ge;
  logic                         d_found;
  logic                         d_rej;
  logic                         d_drop;
  logic signed [VALUE_BITS-1:0] max_val;
  logic signed [63:0]           min_wide;
  logic signed [63:0]           max_wide;

  // request value as a VALUE_BITS signed number
  assign req_value = VALUE_BITS'({32'b0, value_in});

  // per-cell compare against the request
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
    assign valid[i] = (used > USED_W'(i));
    assign lt[i]    = valid[i] && (cell_val[i] < req_value);
    assign eq[i]    = valid[i] && (cell_val[i] == req_value);
    if (i == 0) begin : g_first
      assign first_ge[i] = !lt[i];
    end else begin : g_rest
      assign first_ge[i] = !lt[i] && lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_top
      assign last[i] = valid[i];
    end else begin : g_low
      assign last[i] = valid[i] && !valid[i+1];
    end
  end

  // decision for the request
  always_comb begin
    d_op    = OP_NOP;
    d_tgt   = '0;
    d_ge    = '0;
    d_found = 1'b0;
    d_rej   = 1'b0;
    d_drop  = 1'b0;
    present = |eq;
    eq_cnt  = '0;
    tgt_cnt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (eq[i]) begin
        eq_cnt = eq_cnt | cell_cnt[i];
      end
    end
    unique case (mode)
      MODE_INSERT: begin
        d_found = present;
        if (present) begin
          if (eq_cnt == COUNT_MAX || total == TOTAL_MAX) begin
            d_rej = 1'b1;
          end else begin
            d_op  = OP_INC;
            d_tgt = eq;
          end
        end else if (used == USED_W'(CAPACITY) || total == TOTAL_MAX) begin
          d_rej = 1'b1;
        end else begin
          d_op  = OP_INS;
          d_tgt = first_ge;
          d_ge  = ~lt;
        end
      end
      MODE_REMOVE: begin
        d_found = present;
        if (present) begin
          d_tgt  = eq;
          d_ge   = ~lt;
          d_drop = 1'b1;
        end
      end
      MODE_REMOVE_MIN: begin
        if (used != '0) begin
          d_tgt  = CAPACITY'(1);
          d_ge   = '1;
          d_drop = 1'b1;
        end
      end
      MODE_REMOVE_MAX: begin
        if (used != '0) begin
          d_tgt  = last;
          d_ge   = last;
          d_drop = 1'b1;
        end
      end
      MODE_LOOKUP: begin
        d_found = present;
      end
      default: begin
        d_op = OP_NOP;
      end
    endcase
    // one occurrence left means the cell goes away
    for (int i = 0; i < CAPACITY; i++) begin
      if (d_tgt[i]) begin
        tgt_cnt = tgt_cnt | cell_cnt[i];
      end
    end
    if (d_drop) begin
      d_op = (tgt_cnt > COUNT_W'(1)) ? OP_DEC : OP_DEL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      dec_op    <= d_op;
      dec_tgt   <= d_tgt;
      dec_ge    <= d_ge;
      dec_value <= req_value;
      dec_found <= d_found;
      dec_rej   <= d_rej;
    end
  end

  // cell update: shift up on insert, shift down on delete
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] up_val;
    logic        [COUNT_W-1:0]    up_cnt;
    logic signed [VALUE_BITS-1:0] dn_val;
    logic        [COUNT_W-1:0]    dn_cnt;
    if (i == 0) begin : g_up0
      assign up_val = cell_val[i];
      assign up_cnt = cell_cnt[i];
    end else begin : g_upn
      assign up_val = cell_val[i-1];
      assign up_cnt = cell_cnt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_dntop
      assign dn_val = cell_val[i];
      assign dn_cnt = '0;
    end else begin : g_dnn
      assign dn_val = cell_val[i+1];
      assign dn_cnt = cell_cnt[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.apply) begin
        unique case (dec_op)
          OP_INC: begin
            if (dec_tgt[i]) begin
              cell_cnt[i] <= cell_cnt[i] + COUNT_W'(1);
            end
          end
          OP_DEC: begin
            if (dec_tgt[i]) begin
              cell_cnt[i] <= cell_cnt[i] - COUNT_W'(1);
            end
          end
          OP_INS: begin
            if (dec_tgt[i]) begin
              cell_val[i] <= dec_value;
              cell_cnt[i] <= COUNT_W'(1);
            end else if (dec_ge[i]) begin
              cell_val[i] <= up_val;
              cell_cnt[i] <= up_cnt;
            end
          end
          OP_DEL: begin
            if (dec_ge[i]) begin
              cell_val[i] <= dn_val;
              cell_cnt[i] <= dn_cnt;
            end
          end
          default: begin
            cell_cnt[i] <= cell_cnt[i];
          end
        endcase
      end
    end
  end

  // entry and occurrence totals
  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      total <= '0;
    end else if (cmd.apply) begin
      unique case (dec_op)
        OP_INC: begin
          total <= total + TOTAL_W'(1);
        end
        OP_INS: begin
          used  <= used + USED_W'(1);
          total <= total + TOTAL_W'(1);
        end
        OP_DEC: begin
          total <= total - TOTAL_W'(1);
        end
        OP_DEL: begin
          used  <= used - USED_W'(1);
          total <= total - TOTAL_W'(1);
        end
        default: begin
          total <= total;
        end
      endcase
    end
  end

  // largest stored value sits in the last valid cell
  always_comb begin
    max_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (last[i]) begin
        max_val = max_val | cell_val[i];
      end
    end
    min_wide = 64'(cell_val[0]);
    max_wide = 64'(max_val);
  end

  // result capture from the updated array
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_found <= dec_found;
      res_rej   <= dec_rej;
      res_total <= total;
      res_valid <= (used != '0);
      res_min   <= (used != '0) ? min_wide[OUT_VAL_W-1:0] : '0;
      res_max   <= (used != '0) ? max_wide[OUT_VAL_W-1:0] : '0;
    end
  end

  assign out_data = {1'b0, res_rej, res_total, res_valid, res_max, res_min, res_found};

endmodule

FILE: rtl/core/sorted_multiset_table_core.sv
// ----------------------------------------------------------------------------
// sorted_multiset_table_core
// Bounded sorted multiset of signed values with per-value occurrence counts.
// ----------------------------------------------------------------------------
// A request passes through a decide step and an apply step. In the accept
// cycle every cell of the sorted array is compared against the request
// value and the update is decided. In the next cycle the cell array shifts
// or updates its counts. The result is then captured into the output
// register once the output side has room, which is also the cycle in which
// the next request can be accepted; no new request is taken before the
// previous one has been applied. While a result waits downstream, one
// further request is still taken and processed. After that, s_tready stays
// low until the waiting result is accepted. No clearing pass after reset.
module sorted_multiset_table_core #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [smt_pkg::IN_DATA_W-1:0]   s_tdata,   // [31:0] value
  input  logic [smt_pkg::MODE_W-1:0]      s_tuser,   // [2:0] mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] found, [32:1] min_value, [64:33] max_value, [65] extremes_valid,
  // [85:66] total_count, [86] rejected, [87] zero
  output logic [smt_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import smt_pkg::*;

  cmd_t cmd;

  // request sequencing
  smt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // cell array and result register
  smt_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .mode     (s_tuser),
    .value_in (s_tdata),
    .out_data (m_tdata)
  );

  // decide and apply never overlap
  assert property (@(posedge clk) disable iff (rst) !(cmd.decide && cmd.apply))
    else $error("decide and apply in the same cycle");

  // every accepted request is applied in the next cycle
  assert property (@(posedge clk) disable iff (rst) cmd.decide |=> cmd.apply)
    else $error("accepted request not applied");

  // no request taken while the array updates
  assert property (@(posedge clk) disable iff (rst) cmd.apply |-> !s_tready)
    else $error("request accepted during apply");

  // extremes are valid exactly when something is stored
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[65] == (m_tdata[85:66] != 20'd0)))
    else $error("extremes_valid disagrees with total_count");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted multiset table core. Requests are
// streamed in with random gaps and results are drained with random stalls.
// Each result is compared field by field with an in-bench model of the
// multiset. Covered: empty-set corners, full table, repeated occurrences of
// one value, reinsertion after emptying, unused modes, and a random
// fill/drain mix.
// ----------------------------------------------------------------------------
module tb_top;
  import smt_pkg::*;

  localparam int CAPACITY   = 16;
  localparam int GAP_MAX    = 10;
  localparam int POOL_N     = 24;
  localparam int HOT_REPEAT = 20;

  // mode codes the block treats as no-ops
  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  // corner values of the signed operand
  localparam logic [31:0] VAL_MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] VAL_MOST_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_NEG_ONE  = 32'hFFFF_FFFF;

  typedef struct {
    logic              found;
    logic [31:0]       min_value;
    logic [31:0]       max_value;
    logic              extremes_valid;
    logic [TOTAL_W-1:0] total_count;
    logic              rejected;
  } set_result_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;  // [31:0] value
  logic [MODE_W-1:0]     s_tuser  = '0;  // [2:0] mode
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [0] found, [32:1] min, [64:33] max, [65] valid, [85:66] total, [86] rejected
  logic [OUT_DATA_W-1:0] m_tdata;

  sorted_multiset_table_core #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(32)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #5 clk = ~clk;

  // model of the multiset, entries kept in ascending signed order
  logic signed [31:0] set_value [CAPACITY];
  logic [COUNT_W-1:0] set_count [CAPACITY] = '{default: '0};
  int                 set_used  = 0;
  logic [TOTAL_W-1:0] set_total = '0;

  set_result_t pending_results[$];
  int idle_max        = 0;
  int err_count       = 0;
  int requests_sent   = 0;
  int results_seen    = 0;
  int inserts_refused = 0;
  int peak_used       = 0;

  // drop one occurrence of entry idx, closing the gap when it empties
  function automatic void drop_occurrence(int idx);
    if (set_count[idx] > 1) begin
      set_count[idx]--;
    end else begin
      for (int j = idx; j < set_used - 1; j++) begin
        set_value[j] = set_value[j + 1];
        set_count[j] = set_count[j + 1];
      end
      set_used--;
      set_count[set_used] = '0;
    end
    set_total--;
  endfunction

  // apply one request to the model and return the result it should produce
  function automatic set_result_t next_multiset_result(logic [MODE_W-1:0] mode,
                                                       logic signed [31:0] value);
    set_result_t r;
    int          pos;
    logic        present;
    pos = 0;
    while (pos < set_used && set_value[pos] < value) pos++;
    present    = (pos < set_used) && (set_value[pos] == value);
    r.found    = 1'b0;
    r.rejected = 1'b0;
    case (mode)
      MODE_INSERT: begin
        r.found = present;
        if (present) begin
          if (set_count[pos] == COUNT_MAX || set_total == TOTAL_MAX) begin
            r.rejected = 1'b1;
          end else begin
            set_count[pos]++;
            set_total++;
          end
        end else if (set_used == CAPACITY || set_total == TOTAL_MAX) begin
          r.rejected = 1'b1;
        end else begin
          for (int j = set_used; j > pos; j--) begin
            set_value[j] = set_value[j - 1];
            set_count[j] = set_count[j - 1];
          end
          set_value[pos] = value;
          set_count[pos] = 1;
          set_used++;
          set_total++;
        end
      end
      MODE_REMOVE: begin
        r.found = present;
        if (present) drop_occurrence(pos);
      end
      MODE_REMOVE_MIN: begin
        if (set_used > 0) drop_occurrence(0);
      end
      MODE_REMOVE_MAX: begin
        if (set_used > 0) drop_occurrence(set_used - 1);
      end
      MODE_LOOKUP: begin
        r.found = present;
      end
      default: ;
    endcase
    r.extremes_valid = (set_used > 0);
    if (set_used > 0) begin
      r.min_value = set_value[0];
      r.max_value = set_value[set_used - 1];
    end else begin
      r.min_value = '0;
      r.max_value = '0;
    end
    r.total_count = set_total;
    if (set_used > peak_used) peak_used = set_used;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (err_count < 30)
      $display("[%0t] result %0d: %s got %h expected %h", $realtime, results_seen,
               field, got, want);
    err_count++;
  endtask

  // send one request, waiting a random gap first; valid stays high afterwards
  task automatic send_request(logic [MODE_W-1:0] mode, logic [31:0] value);
    int          gap;
    set_result_t want;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = next_multiset_result(mode, value);
    if (want.rejected) inserts_refused++;
    pending_results.push_back(want);
    requests_sent++;
  endtask

  // result side: random stall before each result
  initial begin : result_sink
    int stall;
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, idle_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    set_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[0] !== want.found)
          report_mismatch("found", m_tdata[0], want.found);
        if (m_tdata[32:1] !== want.min_value)
          report_mismatch("min_value", m_tdata[32:1], want.min_value);
        if (m_tdata[64:33] !== want.max_value)
          report_mismatch("max_value", m_tdata[64:33], want.max_value);
        if (m_tdata[65] !== want.extremes_valid)
          report_mismatch("extremes_valid", m_tdata[65], want.extremes_valid);
        if (m_tdata[85:66] !== want.total_count)
          report_mismatch("total_count", m_tdata[85:66], want.total_count);
        if (m_tdata[86] !== want.rejected)
          report_mismatch("rejected", m_tdata[86], want.rejected);
      end
      results_seen++;
    end
  end

  // corners on an empty and a small set, unused modes, reinsert after emptying
  task automatic test_directed();
    idle_max = GAP_MAX;
    send_request(MODE_REMOVE_MIN, $urandom());
    send_request(MODE_REMOVE_MAX, $urandom());
    send_request(MODE_REMOVE, 32'd5);
    send_request(MODE_LOOKUP, 32'd0);
    send_request(MODE_INSERT, VAL_MOST_NEG);
    send_request(MODE_INSERT, VAL_MOST_POS);
    send_request(MODE_INSERT, 32'd0);
    send_request(MODE_INSERT, VAL_NEG_ONE);
    send_request(MODE_INSERT, VAL_MOST_POS);
    send_request(MODE_LOOKUP, VAL_MOST_POS);
    send_request(MODE_LOOKUP, 32'd1);
    send_request(MODE_REMOVE, VAL_MOST_POS);
    send_request(MODE_REMOVE, VAL_MOST_POS);
    send_request(MODE_REMOVE, 32'd12345);
    send_request(MODE_SPARE_5, 32'd0);
    send_request(MODE_SPARE_6, VAL_MOST_NEG);
    send_request(MODE_SPARE_7, VAL_NEG_ONE);
    send_request(MODE_REMOVE_MIN, $urandom());
    send_request(MODE_REMOVE_MAX, $urandom());
    send_request(MODE_REMOVE_MIN, $urandom());
    send_request(MODE_REMOVE_MAX, $urandom());
    send_request(MODE_INSERT, 32'h5555_AAAA);
    send_request(MODE_REMOVE_MAX, $urandom());
  endtask

  // fill every entry, hit the full-table refusal, then drain past empty
  task automatic test_full_table();
    idle_max = GAP_MAX;
    for (int i = CAPACITY - 1; i >= 0; i--)
      send_request(MODE_INSERT, (i - 8) * 100000);
    send_request(MODE_INSERT, VAL_MOST_POS);
    send_request(MODE_INSERT, VAL_MOST_NEG);
    send_request(MODE_INSERT, -800000);
    send_request(MODE_LOOKUP, -800000);
    send_request(MODE_REMOVE, 32'd0);
    send_request(MODE_INSERT, 32'd50);
    send_request(MODE_INSERT, 32'd60);
    for (int i = 0; i < CAPACITY + 3; i++)
      send_request(i[0] ? MODE_REMOVE_MAX : MODE_REMOVE_MIN, $urandom());
  endtask

  // build up a count on one value back to back, then remove every occurrence
  task automatic test_repeated_count();
    logic [31:0] hot_value;
    hot_value = 32'hC0FF_EE00;
    idle_max  = 0;
    for (int i = 0; i < HOT_REPEAT; i++) send_request(MODE_INSERT, hot_value);
    idle_max = GAP_MAX;
    send_request(MODE_INSERT, 32'd1);
    send_request(MODE_LOOKUP, hot_value);
    send_request(MODE_REMOVE, 32'd1);
    idle_max = 0;
    for (int i = 0; i < HOT_REPEAT; i++) send_request(MODE_REMOVE, hot_value);
    idle_max = GAP_MAX;
    send_request(MODE_REMOVE, hot_value);
  endtask

  // random mix in alternating fill and drain phases over a small value pool
  task automatic test_random_mix();
    logic [31:0]       pool [POOL_N];
    logic [MODE_W-1:0] spare_modes [3];
    logic [MODE_W-1:0] mode;
    logic [31:0]       value;
    int                pick;
    int                ins_cut;
    spare_modes = '{MODE_SPARE_5, MODE_SPARE_6, MODE_SPARE_7};
    for (int phase = 0; phase < 8; phase++) begin
      idle_max = (phase % 4 == 2) ? 0 : GAP_MAX;
      ins_cut  = phase[0] ? 25 : 50;
      for (int k = 0; k < POOL_N; k++)
        pool[k] = (k < 8) ? 32'($urandom_range(0, 40)) - 32'd20 : $urandom();
      for (int n = 0; n < 90; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < ins_cut) mode = MODE_INSERT;
        else if (pick < ins_cut + 15) mode = MODE_REMOVE;
        else if (pick < 65) mode = MODE_REMOVE;
        else if (pick < 72) mode = MODE_REMOVE_MIN;
        else if (pick < 80) mode = MODE_REMOVE_MAX;
        else if (pick < 95) mode = MODE_LOOKUP;
        else mode = spare_modes[$urandom_range(0, 2)];
        pick = $urandom_range(0, 9);
        if (pick < 7) value = pool[$urandom_range(0, POOL_N - 1)];
        else if (pick == 7) value = $urandom();
        else if (pick == 8)
          case ($urandom_range(0, 3))
            0: value = VAL_MOST_NEG;
            1: value = VAL_MOST_POS;
            2: value = VAL_NEG_ONE;
            default: value = 32'd0;
          endcase
        else value = pool[$urandom_range(0, POOL_N - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        send_request(mode, value);
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_repeated_count();
    test_random_mix();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("requests %0d, results %0d, refused inserts %0d, peak entries %0d",
             requests_sent, results_seen, inserts_refused, peak_used);
    $display("covered empty-set corners, full table, repeated counts and random mix");
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
